[hw/rtl/cube_map_face_uv_defines.svh]
// Assertion macros shared by the cube map face block.
`ifndef CUBE_MAP_FACE_UV_DEFINES_SVH
`define CUBE_MAP_FACE_UV_DEFINES_SVH

`ifndef SYNTH

`define CMFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cube_map_face_uv: implication check failed");

`define CMFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cube_map_face_uv: next-cycle check failed");

`else

`define CMFU_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define CMFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/cmfu_pkg.sv]
// Types and constants for the cube map face block.
package cmfu_pkg;

	localparam int COMP_BITS  = 16;
	localparam int FRAC_BITS  = 14;
	localparam int QBITS      = FRAC_BITS + 1;
	localparam int COORD_BITS = FRAC_BITS + 2;
	localparam int REM_BITS   = COMP_BITS + 1;

	localparam logic [COORD_BITS-1:0] FX_ONE  = COORD_BITS'(1) << FRAC_BITS;
	localparam logic [COORD_BITS-1:0] FX_HALF = COORD_BITS'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		FACE_TOP    = 3'd0,
		FACE_BOTTOM = 3'd1,
		FACE_FRONT  = 3'd2,
		FACE_BACK   = 3'd3,
		FACE_LEFT   = 3'd4,
		FACE_RIGHT  = 3'd5
	} face_t;

	typedef struct packed {
		face_t                 face;
		logic [COMP_BITS-1:0]  depth;
		logic [COMP_BITS-1:0]  den;
		logic                  neg_u;
		logic                  neg_v;
		logic                  qneg_u;
		logic                  qneg_v;
		logic [REM_BITS-1:0]   rem_u;
		logic [REM_BITS-1:0]   rem_v;
		logic [QBITS-1:0]      quo_u;
		logic [QBITS-1:0]      quo_v;
	} cell_t;

endpackage

[hw/rtl/cmfu_dir_if.sv]
// Direction request channel.
interface cmfu_dir_if;
	import cmfu_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [COMP_BITS-1:0] dir_x;
	logic signed [COMP_BITS-1:0] dir_y;
	logic signed [COMP_BITS-1:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

[hw/rtl/cmfu_res_if.sv]
// Face result request channel.
interface cmfu_res_if;
	import cmfu_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [2:0]                   face;
	logic signed [COORD_BITS-1:0] coord_u;
	logic signed [COORD_BITS-1:0] coord_v;
	logic [COMP_BITS-1:0]         depth;

	modport source (output valid, output face, output coord_u, output coord_v,
		output depth, input ready);
	modport sink (input valid, input face, input coord_u, input coord_v,
		input depth, output ready);
endinterface

[hw/rtl/cmfu_select.sv]
// Major axis pick, face code and divider setup; first pipeline stage.
module cmfu_select (
	input  logic              clk,
	input  logic              arst_n,
	cmfu_dir_if.sink          dir,
	input  logic              take_dn,
	output logic              vld_out,
	output cmfu_pkg::cell_t   dat_out
);
	import cmfu_pkg::*;

	logic                 xn, yn, zn;
	logic [COMP_BITS-1:0] xm, ym, zm;
	logic                 y_major, z_major;
	logic                 take;
	logic                 vld_s1;
	cell_t                nxt;
	cell_t                dat_s1;

	assign xn = dir.dir_x[COMP_BITS-1];
	assign yn = dir.dir_y[COMP_BITS-1];
	assign zn = dir.dir_z[COMP_BITS-1];
	assign xm = xn ? COMP_BITS'(~dir.dir_x + 1'b1) : COMP_BITS'(dir.dir_x);
	assign ym = yn ? COMP_BITS'(~dir.dir_y + 1'b1) : COMP_BITS'(dir.dir_y);
	assign zm = zn ? COMP_BITS'(~dir.dir_z + 1'b1) : COMP_BITS'(dir.dir_z);

	assign y_major = (ym >= xm) && (ym >= zm) && (ym != '0);
	assign z_major = (zm >= xm) && (zm >= ym) && (zm != '0);

	always_comb begin
		nxt       = '0;
		nxt.quo_u = '0;
		nxt.quo_v = '0;
		priority if (y_major) begin
			nxt.face   = yn ? FACE_TOP : FACE_BOTTOM;
			nxt.depth  = ym;
			nxt.den    = ym;
			nxt.neg_u  = 1'b1;
			nxt.neg_v  = 1'b1;
			nxt.qneg_u = zn ^ yn;
			nxt.qneg_v = xn;
			nxt.rem_u  = REM_BITS'(zm);
			nxt.rem_v  = REM_BITS'(xm);
		end else if (z_major) begin
			nxt.face   = zn ? FACE_BACK : FACE_FRONT;
			nxt.depth  = zm;
			nxt.den    = zm;
			nxt.neg_u  = 1'b0;
			nxt.neg_v  = 1'b0;
			nxt.qneg_u = xn ^ zn;
			nxt.qneg_v = yn;
			nxt.rem_u  = REM_BITS'(xm);
			nxt.rem_v  = REM_BITS'(ym);
		end else if (xm != '0) begin
			nxt.face   = xn ? FACE_RIGHT : FACE_LEFT;
			nxt.depth  = xm;
			nxt.den    = xm;
			nxt.neg_u  = 1'b1;
			nxt.neg_v  = 1'b0;
			nxt.qneg_u = zn ^ xn;
			nxt.qneg_v = yn;
			nxt.rem_u  = REM_BITS'(zm);
			nxt.rem_v  = REM_BITS'(ym);
		end else begin
			// null direction: 0/1 gives a zero quotient, hence 0.5
			nxt.face   = FACE_TOP;
			nxt.depth  = '0;
			nxt.den    = COMP_BITS'(1);
			nxt.neg_u  = 1'b0;
			nxt.neg_v  = 1'b0;
			nxt.qneg_u = 1'b0;
			nxt.qneg_v = 1'b0;
			nxt.rem_u  = '0;
			nxt.rem_v  = '0;
		end
	end

	assign take      = !vld_s1 || take_dn;
	assign dir.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= dir.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && dir.valid) begin
			dat_s1 <= nxt;
		end
	end

	assign vld_out = vld_s1;
	assign dat_out = dat_s1;
endmodule

[hw/rtl/cmfu_div_cell.sv]
// One restoring-division cell: one quotient bit for both coordinates.
module cmfu_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  cmfu_pkg::cell_t   dat_in,
	output logic              take_up,
	input  logic              take_dn,
	output logic              vld_out,
	output cmfu_pkg::cell_t   dat_out
);
	import cmfu_pkg::*;

	logic                ge_u, ge_v;
	logic [REM_BITS-1:0] dif_u, dif_v;
	logic [REM_BITS-1:0] den_x;
	cell_t               nxt;
	cell_t               dat_q;
	logic                vld_q;

	assign den_x = REM_BITS'(dat_in.den);
	assign ge_u  = dat_in.rem_u >= den_x;
	assign ge_v  = dat_in.rem_v >= den_x;
	assign dif_u = ge_u ? (dat_in.rem_u - den_x) : dat_in.rem_u;
	assign dif_v = ge_v ? (dat_in.rem_v - den_x) : dat_in.rem_v;

	always_comb begin
		nxt       = dat_in;
		nxt.rem_u = {dif_u[REM_BITS-2:0], 1'b0};
		nxt.rem_v = {dif_v[REM_BITS-2:0], 1'b0};
		nxt.quo_u = {dat_in.quo_u[QBITS-2:0], ge_u};
		nxt.quo_v = {dat_in.quo_v[QBITS-2:0], ge_v};
	end

	assign take_up = !vld_q || take_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_up) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_up && vld_in) begin
			dat_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign dat_out = dat_q;
endmodule

[hw/rtl/cmfu_finish.sv]
// Halving, sign and output register of the face coordinates.
module cmfu_finish (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  cmfu_pkg::cell_t   dat_in,
	output logic              take_up,
	cmfu_res_if.source        res
);
	import cmfu_pkg::*;

	function automatic logic [COORD_BITS-1:0] coord_of(
		input logic [QBITS-1:0] quo,
		input logic             qneg,
		input logic             neg
	);
		logic [COORD_BITS-1:0] q;
		logic [COORD_BITS-1:0] s;
		logic [COORD_BITS-1:0] h;
		q = COORD_BITS'(quo);
		s = (qneg && (quo != '0)) ? (FX_ONE - q) : (FX_ONE + q);
		h = s >> 1;
		return neg ? COORD_BITS'(~h + 1'b1) : h;
	endfunction

	logic                  vld_q;
	logic [2:0]            face_q;
	logic [COORD_BITS-1:0] u_q, v_q;
	logic [COMP_BITS-1:0]  depth_q;

	assign take_up = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take_up) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_up && vld_in) begin
			face_q  <= 3'(dat_in.face);
			u_q     <= coord_of(dat_in.quo_u, dat_in.qneg_u, dat_in.neg_u);
			v_q     <= coord_of(dat_in.quo_v, dat_in.qneg_v, dat_in.neg_v);
			depth_q <= dat_in.depth;
		end
	end

	assign res.valid   = vld_q;
	assign res.face    = face_q;
	assign res.coord_u = u_q;
	assign res.coord_v = v_q;
	assign res.depth   = depth_q;
endmodule

[hw/rtl/cube_map_face_uv.sv]
// Top level: cube map face selection with face coordinates.
// Usage:
//   dir carries one direction request (dir_x, dir_y, dir_z, signed) per
//   valid/ready handshake; res returns one request per direction with the
//   face code, coord_u and coord_v in signed Q2.14, and the major magnitude
//   as depth. Results leave in input order.
//   From accept to res.valid a request passes the select stage, which loads
//   at the accept edge, then 15 division cells (one quotient bit each, both
//   coordinates in parallel) and one output register. A new direction is
//   accepted every cycle unless res is stalled with every stage full.
//   Each stage holds its own valid bit and loads whenever it is empty or
//   its contents move on, so bubbles close up while res is stalled; the
//   input stalls only once every stage holds a request.
//   Reset clears all valid bits; the block is then empty and ready.
//   A null direction gives face 0, both coordinates 0.5 and depth 0.
`include "cube_map_face_uv_defines.svh"

module cube_map_face_uv (
	input  logic        clk,
	input  logic        arst_n,
	cmfu_dir_if.sink    dir,
	cmfu_res_if.source  res
);
	import cmfu_pkg::*;

	localparam logic signed [COORD_BITS-1:0] C_MAX = FX_ONE;
	localparam logic signed [COORD_BITS-1:0] C_MIN = -C_MAX;
	localparam logic signed [COORD_BITS-1:0] C_HALF = FX_HALF;

	logic  cell_vld  [0:QBITS];
	logic  cell_take [0:QBITS];
	cell_t cell_dat  [0:QBITS];

	cmfu_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.dir     (dir),
		.take_dn (cell_take[0]),
		.vld_out (cell_vld[0]),
		.dat_out (cell_dat[0])
	);

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		cmfu_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (cell_vld[i]),
			.dat_in  (cell_dat[i]),
			.take_up (cell_take[i]),
			.take_dn (cell_take[i+1]),
			.vld_out (cell_vld[i+1]),
			.dat_out (cell_dat[i+1])
		);
	end

	cmfu_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (cell_vld[QBITS]),
		.dat_in  (cell_dat[QBITS]),
		.take_up (cell_take[QBITS]),
		.res     (res)
	);

	`CMFU_ASSERT_NEXT(a_last_cell_lands, clk, arst_n, cell_vld[QBITS] && cell_take[QBITS], res.valid)
	`CMFU_ASSERT_IMPL(a_null_result, clk, arst_n, res.valid && (res.depth == '0), (res.face == 3'(FACE_TOP)) && (res.coord_u == C_HALF) && (res.coord_v == C_HALF))
	`CMFU_ASSERT_IMPL(a_coord_range, clk, arst_n, res.valid, ($signed(res.coord_u) <= C_MAX) && ($signed(res.coord_u) >= C_MIN) && ($signed(res.coord_v) <= C_MAX) && ($signed(res.coord_v) >= C_MIN))
endmodule

[tb/sv/tb_cube_map_face_uv.sv]
// Testbench for cube_map_face_uv: random and corner directions checked against a face predictor.
module tb_cube_map_face_uv;
	timeunit 1ns;
	timeprecision 1ps;

	import cmfu_pkg::*;

	typedef struct {
		face_t                        face;
		logic signed [COORD_BITS-1:0] coord_u;
		logic signed [COORD_BITS-1:0] coord_v;
		logic [COMP_BITS-1:0]         depth;
	} face_result_t;

	class face_scoreboard;
		face_result_t expected_faces[$];
		int           errors;

		// +-floor((num/den + 1) / 2) in Q2.FRAC_BITS, quotient truncated toward zero
		function logic signed [COORD_BITS-1:0] face_coord_fx(int num, int den, bit negate);
			int unit;
			int nmag;
			int dmag;
			int quo;
			int sum;
			int half;
			bit quo_neg;
			unit = 1 << FRAC_BITS;
			nmag = (num < 0) ? -num : num;
			dmag = (den < 0) ? -den : den;
			quo = (nmag << FRAC_BITS) / dmag;
			if (quo > unit)
				quo = unit;
			quo_neg = ((num < 0) != (den < 0)) && (quo != 0);
			sum = quo_neg ? (unit - quo) : (unit + quo);
			half = sum >> 1;
			return negate ? COORD_BITS'(-half) : COORD_BITS'(half);
		endfunction

		function face_result_t predict_face(int x, int y, int z);
			face_result_t r;
			int ax;
			int ay;
			int az;
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			az = (z < 0) ? -z : z;
			if (ay >= ax && ay >= az && ay != 0) begin
				r.face    = (y < 0) ? FACE_TOP : FACE_BOTTOM;
				r.coord_u = face_coord_fx(z, y, 1'b1);
				r.coord_v = face_coord_fx(x, ay, 1'b1);
				r.depth   = COMP_BITS'(ay);
			end else if (az >= ax && az >= ay && az != 0) begin
				r.face    = (z < 0) ? FACE_BACK : FACE_FRONT;
				r.coord_u = face_coord_fx(x, z, 1'b0);
				r.coord_v = face_coord_fx(y, az, 1'b0);
				r.depth   = COMP_BITS'(az);
			end else if (ax != 0) begin
				r.face    = (x < 0) ? FACE_RIGHT : FACE_LEFT;
				r.coord_u = face_coord_fx(z, x, 1'b1);
				r.coord_v = face_coord_fx(y, ax, 1'b0);
				r.depth   = COMP_BITS'(ax);
			end else begin
				r.face    = FACE_TOP;
				r.coord_u = COORD_BITS'(1 << (FRAC_BITS - 1));
				r.coord_v = COORD_BITS'(1 << (FRAC_BITS - 1));
				r.depth   = '0;
			end
			return r;
		endfunction

		function void note_direction(logic signed [COMP_BITS-1:0] x,
			logic signed [COMP_BITS-1:0] y, logic signed [COMP_BITS-1:0] z);
			expected_faces.push_back(predict_face(int'(x), int'(y), int'(z)));
		endfunction

		function void check_result(logic [2:0] face, logic signed [COORD_BITS-1:0] coord_u,
			logic signed [COORD_BITS-1:0] coord_v, logic [COMP_BITS-1:0] depth);
			face_result_t e;
			if (expected_faces.size() == 0) begin
				$error("unexpected result request: face %0d u %0d v %0d depth %0d",
					face, coord_u, coord_v, depth);
				errors++;
				return;
			end
			e = expected_faces.pop_front();
			if (face !== e.face) begin
				$error("face: expected %0d, actual %0d", e.face, face);
				errors++;
			end
			if (coord_u !== e.coord_u) begin
				$error("coord_u: expected %0d, actual %0d", e.coord_u, coord_u);
				errors++;
			end
			if (coord_v !== e.coord_v) begin
				$error("coord_v: expected %0d, actual %0d", e.coord_v, coord_v);
				errors++;
			end
			if (depth !== e.depth) begin
				$error("depth: expected %0d, actual %0d", e.depth, depth);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bit send_idle;
	bit recv_idle;
	bit recv_hold_req;

	face_scoreboard sb = new();

	cmfu_dir_if dir_ch();
	cmfu_res_if res_ch();

	cube_map_face_uv u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.dir    (dir_ch),
		.res    (res_ch)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.face, res_ch.coord_u, res_ch.coord_v, res_ch.depth);
			if (dir_ch.valid && dir_ch.ready)
				sb.note_direction(dir_ch.dir_x, dir_ch.dir_y, dir_ch.dir_z);
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (59) @(posedge clk);
				recv_hold_req = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 2);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_dir(int x, int y, int z);
		dir_ch.valid <= 1'b1;
		dir_ch.dir_x <= COMP_BITS'(x);
		dir_ch.dir_y <= COMP_BITS'(y);
		dir_ch.dir_z <= COMP_BITS'(z);
		@(posedge clk);
		while (!dir_ch.ready)
			@(posedge clk);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			dir_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// magnitude with random sign; +32768 folds onto -32768
	function automatic int with_sign(int m);
		int v;
		v = $urandom_range(0, 1) ? -m : m;
		return (v > 32767) ? -32768 : v;
	endfunction

	task automatic send_random_dir();
		int c[3];
		int major_mag;
		int major_axis;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				for (int i = 0; i < 3; i++)
					c[i] = int'($signed(COMP_BITS'($urandom)));
			end
			3, 4: begin
				for (int i = 0; i < 3; i++)
					c[i] = int'($urandom_range(0, 8)) - 4;
			end
			5, 6, 7: begin
				major_mag = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(1, 32768);
				major_axis = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++)
					c[i] = with_sign($urandom_range(0, major_mag));
				c[major_axis] = with_sign(major_mag);
			end
			default: begin
				major_mag = $urandom_range(0, 32768);
				for (int i = 0; i < 3; i++)
					c[i] = with_sign(major_mag);
				c[$urandom_range(0, 2)] = with_sign($urandom_range(0, major_mag));
			end
		endcase
		send_dir(c[0], c[1], c[2]);
	endtask

	initial begin
		dir_ch.valid <= 1'b0;
		dir_ch.dir_x <= '0;
		dir_ch.dir_y <= '0;
		dir_ch.dir_z <= '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		recv_hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// null, unit axes, extremes, ties
		send_dir(0, 0, 0);
		send_dir(1, 0, 0);
		send_dir(-1, 0, 0);
		send_dir(0, 1, 0);
		send_dir(0, -1, 0);
		send_dir(0, 0, 1);
		send_dir(0, 0, -1);
		send_dir(32767, 0, 0);
		send_dir(-32768, 0, 0);
		send_dir(0, 32767, 0);
		send_dir(0, -32768, 0);
		send_dir(0, 0, 32767);
		send_dir(0, 0, -32768);
		send_dir(-32768, -32768, -32768);
		send_dir(100, 100, 100);
		send_dir(-200, 200, 5);
		send_dir(7, -9, 9);
		send_dir(9, 3, -9);
		send_dir(-32768, 32767, -32767);
		send_dir(32767, -32768, 32767);
		send_dir(1, -32768, -32768);
		send_dir(-32768, 12345, -32768);
		send_dir(3, -3, -3);
		send_dir(-5, 2, -3);
		send_dir(1000, -999, 1);

		for (int blk = 0; blk < 16; blk++) begin
			send_idle = ($urandom_range(0, 2) != 0);
			recv_idle = ($urandom_range(0, 2) != 0);
			if (blk == 8) begin
				send_idle = 1'b0;
				recv_hold_req = 1'b1;
			end
			for (int i = 0; i < 50; i++)
				send_random_dir();
		end

		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (int i = 0; i < 125; i++)
			send_random_dir();
		dir_ch.valid <= 1'b0;

		while (sb.expected_faces.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_cube_map_face_uv: PASS");
		else
			$display("tb_cube_map_face_uv: FAIL");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb_cube_map_face_uv: FAIL");
		$finish;
	end

endmodule
